### rtl/nlp_pkg.sv
// Package for the next lexicographic permutation block.
// Holds sizing constants, the controller state type and the signed compare.
// No dependencies.
package nlp_pkg;

  localparam int MAX_LEN    = 16;
  localparam int ELEM_WIDTH = 32;
  localparam int IDX_W      = $clog2(MAX_LEN);
  localparam int CNT_W      = $clog2(MAX_LEN + 1);

  typedef logic [ELEM_WIDTH-1:0] elem_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_FIND,
    ST_SWPA,
    ST_SWPB,
    ST_EMIT
  } nlp_state_t;

  function automatic logic elem_gt(input elem_t a, input elem_t b);
    elem_gt = $signed(a) > $signed(b);
  endfunction

endpackage

### rtl/nlp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the element store of the permutation block. No dependencies.
module nlp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/next_lexicographic_permutation.sv
// Top level of the next lexicographic permutation block.
// Depends on nlp_pkg and on nlp_ram, which holds the element store.
//
//   channel  ports                                   handshake
//   input    in_elem_value, in_elem_last             start & !busy
//   result   out_value, out_last, out_wrapped,       out_valid, one cycle,
//            out_overflow                            no back pressure
//
// An element loads whenever start is high while busy is low. After the last
// element of a sequence, the block runs the pivot search, the swap partner
// search, the swap writes and the emission in turn; a sequence without an
// ascent skips the partner search and the swap. The single read port of the
// element store makes these steps run one after another. Reset is synchronous
// and clears the fill count, the overflow flag, the controller state and the
// valid flags. Busy stays high from the last element until the cycle in which
// the final result is out.
module next_lexicographic_permutation import nlp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_elem_value,
  input  logic        in_elem_last,
  output logic        out_valid,
  output logic [31:0] out_value,
  output logic        out_last,
  output logic        out_wrapped,
  output logic        out_overflow
);

  nlp_state_t state_r, state_nxt;

  cnt_t  fill_r, fill_nxt;
  logic  ovf_r, ovf_nxt;
  cnt_t  n_r, n_nxt;
  idx_t  iss_r, iss_nxt;
  logic  iss_end_r, iss_end_nxt;
  logic  dv_r, dv_nxt;
  idx_t  daddr_r, daddr_nxt;
  elem_t prev_r, prev_nxt;
  logic  prev_v_r, prev_v_nxt;
  idx_t  piv_r, piv_nxt;
  elem_t pv_r, pv_nxt;
  idx_t  j_r, j_nxt;
  elem_t aj_r, aj_nxt;
  logic  wrap_r, wrap_nxt;
  idx_t  ek_r, ek_nxt;
  logic  out_valid_r, out_valid_nxt;
  logic  out_last_r, out_last_nxt;
  logic  out_wrapped_r, out_wrapped_nxt;
  logic  out_overflow_r, out_overflow_nxt;

  logic  ram_we;
  idx_t  ram_waddr;
  elem_t ram_wdata;
  idx_t  ram_raddr;
  elem_t ram_rdata;

  cnt_t  n_load;
  idx_t  last_idx;
  cnt_t  sfx_start;
  cnt_t  emit_rev;
  idx_t  emit_addr;
  logic  pivot_hit;
  logic  partner_hit;

  nlp_ram #(
    .WIDTH(ELEM_WIDTH),
    .DEPTH(MAX_LEN)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign n_load      = (fill_r < CNT_W'(MAX_LEN)) ? cnt_t'(fill_r + 1'b1) : fill_r;
  assign last_idx    = idx_t'(n_r - 1'b1);
  assign sfx_start   = wrap_r ? '0 : cnt_t'({1'b0, piv_r} + 1'b1);
  assign emit_rev    = cnt_t'(n_r - 1'b1 + sfx_start - {1'b0, ek_r});
  assign emit_addr   = ({1'b0, ek_r} < sfx_start) ? ek_r : emit_rev[IDX_W-1:0];
  assign pivot_hit   = dv_r && prev_v_r && elem_gt(prev_r, ram_rdata);
  assign partner_hit = dv_r && elem_gt(ram_rdata, pv_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && in_elem_last) begin
          state_nxt = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (pivot_hit) begin
          state_nxt = ST_FIND;
        end else if (dv_r && daddr_r == '0) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_FIND: begin
        if (partner_hit) begin
          state_nxt = ST_SWPA;
        end
      end
      ST_SWPA: state_nxt = ST_SWPB;
      ST_SWPB: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (ek_r == last_idx) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    fill_nxt         = fill_r;
    ovf_nxt          = ovf_r;
    n_nxt            = n_r;
    iss_nxt          = iss_r;
    iss_end_nxt      = iss_end_r;
    dv_nxt           = 1'b0;
    daddr_nxt        = daddr_r;
    prev_nxt         = prev_r;
    prev_v_nxt       = prev_v_r;
    piv_nxt          = piv_r;
    pv_nxt           = pv_r;
    j_nxt            = j_r;
    aj_nxt           = aj_r;
    wrap_nxt         = wrap_r;
    ek_nxt           = ek_r;
    out_valid_nxt    = 1'b0;
    out_last_nxt     = out_last_r;
    out_wrapped_nxt  = out_wrapped_r;
    out_overflow_nxt = out_overflow_r;
    ram_we           = 1'b0;
    ram_waddr        = fill_r[IDX_W-1:0];
    ram_wdata        = in_elem_value;
    ram_raddr        = iss_r;

    if ((state_r == ST_SRCH || state_r == ST_FIND) && !iss_end_r) begin
      dv_nxt      = 1'b1;
      daddr_nxt   = iss_r;
      iss_nxt     = idx_t'(iss_r - 1'b1);
      iss_end_nxt = (iss_r == '0);
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (fill_r < CNT_W'(MAX_LEN)) begin
            ram_we   = 1'b1;
            fill_nxt = n_load;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_elem_last) begin
            n_nxt       = n_load;
            iss_nxt     = idx_t'(n_load - 1'b1);
            iss_end_nxt = 1'b0;
            prev_v_nxt  = 1'b0;
          end
        end
      end
      ST_SRCH: begin
        if (pivot_hit) begin
          piv_nxt     = daddr_r;
          pv_nxt      = ram_rdata;
          wrap_nxt    = 1'b0;
          iss_nxt     = last_idx;
          iss_end_nxt = 1'b0;
          dv_nxt      = 1'b0;
        end else if (dv_r) begin
          prev_nxt   = ram_rdata;
          prev_v_nxt = 1'b1;
          if (daddr_r == '0) begin
            wrap_nxt = 1'b1;
            ek_nxt   = '0;
          end
        end
      end
      ST_FIND: begin
        if (partner_hit) begin
          j_nxt  = daddr_r;
          aj_nxt = ram_rdata;
        end
      end
      ST_SWPA: begin
        ram_we    = 1'b1;
        ram_waddr = piv_r;
        ram_wdata = aj_r;
      end
      ST_SWPB: begin
        ram_we    = 1'b1;
        ram_waddr = j_r;
        ram_wdata = pv_r;
        ek_nxt    = '0;
      end
      ST_EMIT: begin
        ram_raddr        = emit_addr;
        out_valid_nxt    = 1'b1;
        out_last_nxt     = (ek_r == last_idx);
        out_wrapped_nxt  = wrap_r;
        out_overflow_nxt = ovf_r;
        ek_nxt           = idx_t'(ek_r + 1'b1);
        if (ek_r == last_idx) begin
          fill_nxt = '0;
          ovf_nxt  = 1'b0;
        end
      end
      default: begin
        fill_nxt = fill_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r            <= n_nxt;
    iss_r          <= iss_nxt;
    iss_end_r      <= iss_end_nxt;
    daddr_r        <= daddr_nxt;
    prev_r         <= prev_nxt;
    prev_v_r       <= prev_v_nxt;
    piv_r          <= piv_nxt;
    pv_r           <= pv_nxt;
    j_r            <= j_nxt;
    aj_r           <= aj_nxt;
    wrap_r         <= wrap_nxt;
    ek_r           <= ek_nxt;
    out_last_r     <= out_last_nxt;
    out_wrapped_r  <= out_wrapped_nxt;
    out_overflow_r <= out_overflow_nxt;
  end

  assign busy         = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_value    = ram_rdata;
  assign out_last     = out_last_r;
  assign out_wrapped  = out_wrapped_r;
  assign out_overflow = out_overflow_r;

endmodule

### tb/sv/next_lexicographic_permutation_test.sv
// Self-checking testbench for the next lexicographic permutation block.
// Depends on nlp_pkg and the next_lexicographic_permutation RTL, which in turn needs nlp_ram.
// Sequences are loaded with random gaps, and every emitted element is checked in order.
module next_lexicographic_permutation_test import nlp_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 250;
  localparam int unsigned IDLE_LIMIT   = 2000;

  typedef struct packed {
    elem_t value;
    logic  last;
    logic  wrapped;
    logic  overflow;
  } perm_elem_t;

  typedef enum {RUN_WIDE, RUN_SMALL, RUN_DESC, RUN_EDGE} run_kind_t;

  class perm_scoreboard;
    elem_t        seq_buf[MAX_LEN];
    int unsigned  fill;
    bit           dropped;
    perm_elem_t   pending[$];
    int unsigned  errors;
    int unsigned  checked;

    function void note_element(input elem_t v, input bit last);
      int    n;
      int    p;
      int    lo;
      int    hi;
      int    j;
      bit    wrp;
      bit    swapped;
      elem_t t;
      perm_elem_t r;
      if (fill < MAX_LEN) begin
        seq_buf[fill] = v;
        fill++;
      end else begin
        dropped = 1'b1;
      end
      if (!last) return;
      n = fill;
      p = n - 1;
      while (p > 0 && !($signed(seq_buf[p]) > $signed(seq_buf[p-1]))) p--;
      wrp = (p == 0);
      lo = p;
      hi = n - 1;
      while (lo < hi) begin
        t = seq_buf[lo];
        seq_buf[lo] = seq_buf[hi];
        seq_buf[hi] = t;
        lo++;
        hi--;
      end
      swapped = wrp;
      for (j = p; j < n && !swapped; j++) begin
        if ($signed(seq_buf[j]) > $signed(seq_buf[p-1])) begin
          t = seq_buf[p-1];
          seq_buf[p-1] = seq_buf[j];
          seq_buf[j] = t;
          swapped = 1'b1;
        end
      end
      for (j = 0; j < n; j++) begin
        r.value    = seq_buf[j];
        r.last     = (j == n - 1);
        r.wrapped  = wrp;
        r.overflow = dropped;
        pending.push_back(r);
      end
      fill = 0;
      dropped = 1'b0;
    endfunction

    function void check_result(input elem_t v, input logic last, input logic wrp,
                               input logic ovf);
      perm_elem_t exp_r;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: value %h last %b wrapped %b overflow %b",
                   v, last, wrp, ovf);
        return;
      end
      exp_r = pending.pop_front();
      if (exp_r.value !== v || exp_r.last !== last || exp_r.wrapped !== wrp ||
          exp_r.overflow !== ovf) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected %h/%b/%b/%b, got %h/%b/%b/%b (value/last/wrapped/overflow)",
                   exp_r.value, exp_r.last, exp_r.wrapped, exp_r.overflow,
                   v, last, wrp, ovf);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_elem_value;
  logic        in_elem_last;
  logic        out_valid;
  logic [31:0] out_value;
  logic        out_last;
  logic        out_wrapped;
  logic        out_overflow;

  perm_scoreboard sb;
  elem_t          run_buf[0:MAX_LEN+7];
  bit             no_idle;
  int unsigned    items_sent;
  int unsigned    runs_sent;
  int unsigned    overflow_runs;
  int unsigned    idle_cycles;

  next_lexicographic_permutation uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_elem_value(in_elem_value),
    .in_elem_last (in_elem_last),
    .out_valid    (out_valid),
    .out_value    (out_value),
    .out_last     (out_last),
    .out_wrapped  (out_wrapped),
    .out_overflow (out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result(out_value, out_last, out_wrapped, out_overflow);
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int unsigned next_gap();
    if (no_idle) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(5, 30);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  task automatic send_element(input elem_t v, input bit last);
    int unsigned gap;
    gap = next_gap();
    start <= 1'b1;
    in_elem_value <= v;
    in_elem_last <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_element(v, last);
    items_sent++;
    if (gap != 0) begin
      start <= 1'b0;
      in_elem_value <= $urandom;
      in_elem_last <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_run(input int unsigned len);
    int unsigned k;
    for (k = 0; k < len; k++) send_element(run_buf[k], k == len - 1);
    runs_sent++;
    if (len > MAX_LEN) overflow_runs++;
  endtask

  task automatic fill_random_run(input int unsigned len, input run_kind_t kind);
    int unsigned k;
    for (k = 0; k < len; k++) begin
      case (kind)
        RUN_WIDE:  run_buf[k] = $urandom;
        RUN_SMALL: run_buf[k] = elem_t'($urandom_range(0, 6) - 3);
        RUN_DESC:  run_buf[k] = (k == 0) ? elem_t'($urandom)
                                         : run_buf[k-1] - elem_t'($urandom_range(0, 3));
        default: begin
          case ($urandom_range(0, 4))
            0: run_buf[k] = 32'h8000_0000;
            1: run_buf[k] = 32'h7fff_ffff;
            2: run_buf[k] = '0;
            3: run_buf[k] = '1;
            default: run_buf[k] = 32'd1;
          endcase
        end
      endcase
    end
  endtask

  initial begin
    int unsigned random_sent;
    int unsigned len;
    int unsigned pick;
    run_kind_t   kind;
    sb = new;
    rst_n = 1'b0;
    start = 1'b0;
    in_elem_value = '0;
    in_elem_last = 1'b0;
    no_idle = 1'b0;
    items_sent = 0;
    runs_sent = 0;
    overflow_runs = 0;
    idle_cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_buf[0] = 32'h7fff_ffff;
    send_run(1);
    run_buf[0] = 32'h8000_0000; run_buf[1] = 32'h7fff_ffff;
    send_run(2);
    run_buf[0] = 32'h7fff_ffff; run_buf[1] = 32'h8000_0000;
    send_run(2);
    run_buf[0] = '1; run_buf[1] = '1; run_buf[2] = '1;
    send_run(3);
    run_buf[0] = 32'd2; run_buf[1] = 32'd3; run_buf[2] = 32'd3; run_buf[3] = 32'd1;
    send_run(4);
    run_buf[0] = '0; run_buf[1] = '1;
    send_run(2);
    run_buf[0] = '1; run_buf[1] = '0;
    send_run(2);
    run_buf[0] = 32'd5; run_buf[1] = 32'd1; run_buf[2] = 32'd4;
    run_buf[3] = 32'd3; run_buf[4] = 32'd2;
    send_run(5);

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (runs_sent == 8 || (runs_sent != 9 && pick == 0))
        len = $urandom_range(MAX_LEN + 1, MAX_LEN + 5);
      else if (runs_sent == 9 || pick == 1)
        len = MAX_LEN;
      else
        len = $urandom_range(1, 8);
      kind = run_kind_t'($urandom_range(0, 3));
      no_idle = ($urandom_range(0, 3) == 0);
      fill_random_run(len, kind);
      send_run(len);
      random_sent += len;
    end

    if (start) start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (3 * MAX_LEN + 10) @(posedge clk);

    if (sb.pending.size() != 0)
      $display("%0d expected results never arrived", sb.pending.size());
    $display("summary: %0d elements in %0d sequences (%0d over capacity), %0d results checked",
             items_sent, runs_sent, overflow_runs, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/nlp_pkg.sv
rtl/nlp_ram.sv
rtl/next_lexicographic_permutation.sv
tb/sv/next_lexicographic_permutation_test.sv
